// ===== rtl/tmse_pkg.sv =====
// package of shared types, constants and the format lookup for the texture size estimator
package tmse_pkg;

  // default cap on the number of mip levels summed
  localparam int unsigned MAX_MIPS_DEF = 15;

  // field widths
  localparam int unsigned DIM_W   = 15;
  localparam int unsigned LVL_W   = 4;
  localparam int unsigned LAYER_W = 12;
  localparam int unsigned FMT_W   = 8;
  localparam int unsigned SMP_W   = 6;
  localparam int unsigned SIZE_W  = 50;
  localparam int unsigned UNIT_W  = 5;

  // internal arithmetic widths
  localparam int unsigned PROD_W  = 2 * DIM_W;               // one level, w * h
  localparam int unsigned TERM_W  = PROD_W + UNIT_W;         // one level in bytes
  localparam int unsigned SUM_W   = 36;                      // mip chain stays below 2^35
  localparam int unsigned LSUM_W  = SUM_W + LAYER_W;         // after layer multiply
  localparam int unsigned TOTAL_W = LSUM_W + SMP_W;          // after sample multiply

  // classified item passed from front to back
  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [LVL_W-1:0]   levels;
    logic [LAYER_W-1:0] layers;
    logic [SMP_W-1:0]   smp;
    logic [UNIT_W-1:0]  unit;
    logic               block;
    logic               known;
  } item_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEVEL,
    BK_LAYER,
    BK_SAMPLE,
    BK_OUT
  } bk_state_t;

  // bytes per texel, or per 4x4 block for compressed families; zero when unknown
  function automatic logic [UNIT_W-1:0] unit_bytes(input logic [FMT_W-1:0] code);
    logic [UNIT_W-1:0] u;
    case (code) inside
      [8'd1:8'd4]:                 u = 5'd16;
      [8'd5:8'd8]:                 u = 5'd12;
      [8'd9:8'd22]:                u = 5'd8;
      [8'd23:8'd47]:               u = 5'd4;
      [8'd48:8'd59]:               u = 5'd2;
      [8'd60:8'd65]:               u = 5'd1;
      8'd67:                       u = 5'd4;
      [8'd70:8'd72]:               u = 5'd8;
      [8'd73:8'd78]:               u = 5'd16;
      [8'd79:8'd81]:               u = 5'd8;
      [8'd82:8'd84]:               u = 5'd16;
      [8'd87:8'd88]:               u = 5'd4;
      [8'd90:8'd93]:               u = 5'd4;
      [8'd94:8'd99]:               u = 5'd16;
      default:                     u = 5'd0;
    endcase
    return u;
  endfunction

  // block compressed families count 4x4 blocks
  function automatic logic is_block(input logic [FMT_W-1:0] code);
    logic b;
    case (code) inside
      [8'd70:8'd84], [8'd94:8'd99]: b = 1'b1;
      default:                      b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/tmse_in_if.sv =====
// input channel interface carrying one texture description per transaction
interface tmse_in_if;
  logic                            valid;
  logic                            ready;
  logic [tmse_pkg::DIM_W-1:0]      tex_width;
  logic [tmse_pkg::DIM_W-1:0]      tex_height;
  logic [tmse_pkg::LVL_W-1:0]      mip_count;
  logic [tmse_pkg::LAYER_W-1:0]    layer_count;
  logic [tmse_pkg::FMT_W-1:0]      pixel_format;
  logic [tmse_pkg::SMP_W-1:0]      samples;

  modport source (
    output valid, tex_width, tex_height, mip_count, layer_count, pixel_format, samples,
    input  ready
  );
  modport sink (
    input  valid, tex_width, tex_height, mip_count, layer_count, pixel_format, samples,
    output ready
  );
endinterface

// ===== rtl/tmse_out_if.sv =====
// result channel interface carrying one size estimate per transaction
interface tmse_out_if;
  logic                          valid;
  logic                          ready;
  logic [tmse_pkg::SIZE_W-1:0]   size_bytes;
  logic                          format_known;

  modport source (output valid, size_bytes, format_known, input ready);
  modport sink   (input valid, size_bytes, format_known, output ready);
endinterface

// ===== rtl/texture_memory_size_estimator.sv =====
// top level of the texture size estimator: front end, two entry queue, back end
// an accepted item is registered in the queue; the back end then runs its level, layer and sample states
// the back end takes a new item only after its result is accepted, and sums levels through a single level multiplier
// unknown formats go straight to the result; the front keeps accepting while the queue has room
// reset: synchronous active-low rst_n empties the queue and returns the back end to idle
module texture_memory_size_estimator #(
  parameter int unsigned MAX_MIPS = tmse_pkg::MAX_MIPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tmse_in_if.sink     in_ch,
  tmse_out_if.source  out_ch
);

  tmse_pkg::item_t f_item;
  logic            f_valid, f_ready;
  tmse_pkg::item_t b_item;
  logic            b_valid, b_ready;

  // classify incoming descriptions
  tmse_front #(
    .MAX_MIPS (MAX_MIPS)
  ) u_front (
    .in_ch   (in_ch),
    .q_item  (f_item),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  // decouple front from back
  tmse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (b_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  // size computation
  tmse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (b_item),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .out_ch  (out_ch)
  );

  // an accepted transaction is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> b_valid)
    else $error("accepted item missing from queue");

  // an unknown format reports zero bytes
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.format_known) |-> (out_ch.size_bytes == '0))
    else $error("unknown format with nonzero size");

  // a known format always gives a nonzero size
  a_known_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.format_known) |-> (out_ch.size_bytes != '0))
    else $error("known format with zero size");

endmodule

// ===== rtl/tmse_front.sv =====
// front end: classifies the format, normalises fields and works out the level count
module tmse_front #(
  parameter int unsigned MAX_MIPS = tmse_pkg::MAX_MIPS_DEF
) (
  tmse_in_if.sink          in_ch,
  output tmse_pkg::item_t  q_item,
  output logic             q_valid,
  input  logic             q_ready
);

  logic [tmse_pkg::DIM_W-1:0] dmax;
  logic [tmse_pkg::LVL_W-1:0] chain_lvls;
  logic [tmse_pkg::LVL_W-1:0] req_lvls;
  logic [tmse_pkg::UNIT_W-1:0] unit;

  assign unit = tmse_pkg::unit_bytes(in_ch.pixel_format);

  // full chain length is the bit length of the larger raw dimension, at least one
  always_comb begin
    dmax = (in_ch.tex_width > in_ch.tex_height) ? in_ch.tex_width : in_ch.tex_height;
    chain_lvls = tmse_pkg::LVL_W'(1);
    for (int i = 1; i < tmse_pkg::DIM_W; i++) begin
      if (dmax[i]) begin
        chain_lvls = tmse_pkg::LVL_W'(i + 1);
      end
    end
  end

  // requested count, then the cap
  always_comb begin
    req_lvls = (in_ch.mip_count == '0) ? chain_lvls : in_ch.mip_count;
    if ({1'b0, req_lvls} > (tmse_pkg::LVL_W + 1)'(MAX_MIPS)) begin
      req_lvls = tmse_pkg::LVL_W'(MAX_MIPS);
    end
  end

  // pack the classified item
  always_comb begin
    q_item.w      = (in_ch.tex_width == '0) ? tmse_pkg::DIM_W'(1) : in_ch.tex_width;
    q_item.h      = (in_ch.tex_height == '0) ? tmse_pkg::DIM_W'(1) : in_ch.tex_height;
    q_item.levels = req_lvls;
    q_item.layers = (in_ch.layer_count == '0) ? tmse_pkg::LAYER_W'(1) : in_ch.layer_count;
    q_item.smp    = (in_ch.samples == '0) ? tmse_pkg::SMP_W'(1) : in_ch.samples;
    q_item.unit   = unit;
    q_item.block  = tmse_pkg::is_block(in_ch.pixel_format);
    q_item.known  = (unit != '0);
  end

  assign q_valid     = in_ch.valid;
  assign in_ch.ready = q_ready;

endmodule

// ===== rtl/tmse_queue.sv =====
// two entry queue between front and back ends
module tmse_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  tmse_pkg::item_t  push_item,
  input  logic             push_valid,
  output logic             push_ready,
  output tmse_pkg::item_t  pop_item,
  output logic             pop_valid,
  input  logic             pop_ready
);

  localparam int unsigned DEPTH = 2;

  tmse_pkg::item_t entry_r [DEPTH];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/tmse_back.sv =====
// back end: sums the mip chain with one area multiplier reused per level, scales by layers and samples
module tmse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tmse_pkg::item_t  q_item,
  input  logic             q_valid,
  output logic             q_ready,
  tmse_out_if.source       out_ch
);

  tmse_pkg::bk_state_t          state_r, state_nxt;
  tmse_pkg::item_t              item_r, item_nxt;
  logic [tmse_pkg::DIM_W-1:0]   w_r, w_nxt;
  logic [tmse_pkg::DIM_W-1:0]   h_r, h_nxt;
  logic [tmse_pkg::LVL_W-1:0]   left_r, left_nxt;
  logic [tmse_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic                         prod_v_r, prod_v_nxt;
  logic [tmse_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [tmse_pkg::LSUM_W-1:0]  lsum_r, lsum_nxt;
  logic [tmse_pkg::SIZE_W-1:0]  res_r, res_nxt;
  logic                         known_r, known_nxt;

  logic [tmse_pkg::DIM_W:0]     w_pad, h_pad;
  logic [tmse_pkg::DIM_W-1:0]   op_w, op_h;
  logic [tmse_pkg::PROD_W-1:0]  lvl_prod;
  logic [tmse_pkg::TERM_W-1:0]  lvl_term;
  logic [tmse_pkg::TOTAL_W-1:0] total;
  logic [tmse_pkg::DIM_W-1:0]   w_half, h_half;

  // level operands: texels, or whole 4x4 blocks for compressed formats
  assign w_pad    = {1'b0, w_r} + (tmse_pkg::DIM_W + 1)'(3);
  assign h_pad    = {1'b0, h_r} + (tmse_pkg::DIM_W + 1)'(3);
  assign op_w     = item_r.block ? tmse_pkg::DIM_W'(w_pad[tmse_pkg::DIM_W:2]) : w_r;
  assign op_h     = item_r.block ? tmse_pkg::DIM_W'(h_pad[tmse_pkg::DIM_W:2]) : h_r;
  assign lvl_prod = tmse_pkg::PROD_W'(op_w) * tmse_pkg::PROD_W'(op_h);
  assign lvl_term = tmse_pkg::TERM_W'(prod_r) * tmse_pkg::TERM_W'(item_r.unit);
  assign total    = tmse_pkg::TOTAL_W'(lsum_r) * tmse_pkg::TOTAL_W'(item_r.smp);

  // next mip dimensions, never below one
  assign w_half = ((w_r >> 1) == '0) ? tmse_pkg::DIM_W'(1) : (w_r >> 1);
  assign h_half = ((h_r >> 1) == '0) ? tmse_pkg::DIM_W'(1) : (h_r >> 1);

  assign out_ch.valid        = (state_r == tmse_pkg::BK_OUT);
  assign out_ch.size_bytes   = res_r;
  assign out_ch.format_known = known_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    left_nxt   = left_r;
    prod_nxt   = prod_r;
    prod_v_nxt = prod_v_r;
    sum_nxt    = sum_r;
    lsum_nxt   = lsum_r;
    res_nxt    = res_r;
    known_nxt  = known_r;
    q_ready    = 1'b0;
    case (state_r)
      tmse_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          item_nxt   = q_item;
          w_nxt      = q_item.w;
          h_nxt      = q_item.h;
          left_nxt   = q_item.levels;
          prod_v_nxt = 1'b0;
          sum_nxt    = '0;
          if (q_item.known) begin
            state_nxt = tmse_pkg::BK_LEVEL;
          end else begin
            res_nxt   = '0;
            known_nxt = 1'b0;
            state_nxt = tmse_pkg::BK_OUT;
          end
        end
      end
      tmse_pkg::BK_LEVEL: begin
        // accumulate the previous level while the next one multiplies
        if (prod_v_r) begin
          sum_nxt = sum_r + tmse_pkg::SUM_W'(lvl_term);
        end
        if (left_r != '0) begin
          prod_nxt   = lvl_prod;
          prod_v_nxt = 1'b1;
          left_nxt   = left_r - tmse_pkg::LVL_W'(1);
          w_nxt      = w_half;
          h_nxt      = h_half;
        end else begin
          prod_v_nxt = 1'b0;
          state_nxt  = tmse_pkg::BK_LAYER;
        end
      end
      tmse_pkg::BK_LAYER: begin
        lsum_nxt  = tmse_pkg::LSUM_W'(sum_r) * tmse_pkg::LSUM_W'(item_r.layers);
        state_nxt = tmse_pkg::BK_SAMPLE;
      end
      tmse_pkg::BK_SAMPLE: begin
        // saturate past fifty bits
        if (total[tmse_pkg::TOTAL_W-1:tmse_pkg::SIZE_W] != '0) begin
          res_nxt = '1;
        end else begin
          res_nxt = total[tmse_pkg::SIZE_W-1:0];
        end
        known_nxt = 1'b1;
        state_nxt = tmse_pkg::BK_OUT;
      end
      tmse_pkg::BK_OUT: begin
        if (out_ch.ready) begin
          state_nxt = tmse_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tmse_pkg::BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tmse_pkg::BK_IDLE;
      prod_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prod_v_r <= prod_v_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    left_r  <= left_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    lsum_r  <= lsum_nxt;
    res_r   <= res_nxt;
    known_r <= known_nxt;
  end

endmodule

// ===== sim/texture_memory_size_estimator_tb.sv =====
// testbench for the texture size estimator: directed and random texture descriptions
`timescale 1ns / 100ps

module texture_memory_size_estimator_tb;

  localparam int unsigned LEVEL_CAP   = tmse_pkg::MAX_MIPS_DEF;
  localparam int unsigned RAND_ITEMS  = 500;
  localparam int unsigned CALM_FROM   = 440;
  localparam longint unsigned SIZE_SAT = (64'd1 << tmse_pkg::SIZE_W) - 64'd1;

  // one texture description as driven on the input channel
  typedef struct {
    logic [tmse_pkg::DIM_W-1:0]   w;
    logic [tmse_pkg::DIM_W-1:0]   h;
    logic [tmse_pkg::LVL_W-1:0]   mips;
    logic [tmse_pkg::LAYER_W-1:0] layers;
    logic [tmse_pkg::FMT_W-1:0]   fmt;
    logic [tmse_pkg::SMP_W-1:0]   smp;
  } tex_desc_t;

  // one expected size estimate
  typedef struct {
    logic [tmse_pkg::SIZE_W-1:0] size_bytes;
    logic                        format_known;
  } size_estimate_t;

  // size predictor and store of pending estimates
  class size_scoreboard;
    size_estimate_t pending_sizes[$];
    int errors;
    int checked;
    int unknown_fmts;
    int saturated;
    int full_chains;

    function new();
      errors = 0;
      checked = 0;
      unknown_fmts = 0;
      saturated = 0;
      full_chains = 0;
    endfunction

    // bytes per texel, or per 4x4 block for the compressed families
    function int unsigned texel_bytes(logic [tmse_pkg::FMT_W-1:0] fmt);
      int unsigned c;
      c = 32'(fmt);
      if (c >= 1 && c <= 4) return 16;
      if (c >= 5 && c <= 8) return 12;
      if (c >= 9 && c <= 22) return 8;
      if (c >= 23 && c <= 47) return 4;
      if (c >= 48 && c <= 59) return 2;
      if (c >= 60 && c <= 65) return 1;
      if (c == 67) return 4;
      if (c >= 70 && c <= 72) return 8;
      if (c >= 73 && c <= 78) return 16;
      if (c >= 79 && c <= 81) return 8;
      if (c >= 82 && c <= 84) return 16;
      if (c == 87 || c == 88) return 4;
      if (c >= 90 && c <= 93) return 4;
      if (c >= 94 && c <= 99) return 16;
      return 0;
    endfunction

    function bit compressed(logic [tmse_pkg::FMT_W-1:0] fmt);
      return (fmt >= 70 && fmt <= 84) || (fmt >= 94 && fmt <= 99);
    endfunction

    function size_estimate_t estimate(tex_desc_t d);
      size_estimate_t r;
      longint unsigned unit, w, h, dmax, sum, total;
      int unsigned levels;
      unit = 64'(texel_bytes(d.fmt));
      r.size_bytes = '0;
      r.format_known = 1'b0;
      if (unit == 0) begin
        unknown_fmts++;
        return r;
      end
      // level count, full chain from the raw larger dimension
      levels = 32'(d.mips);
      if (levels == 0) begin
        full_chains++;
        dmax = (d.w > d.h) ? 64'(d.w) : 64'(d.h);
        levels = 1;
        while (dmax > 1) begin
          dmax = dmax >> 1;
          levels++;
        end
      end
      if (levels > LEVEL_CAP) levels = LEVEL_CAP;
      // sum over the mip chain
      w = (d.w == '0) ? 64'd1 : 64'(d.w);
      h = (d.h == '0) ? 64'd1 : 64'(d.h);
      sum = 0;
      for (int unsigned i = 0; i < levels; i++) begin
        if (compressed(d.fmt))
          sum += ((w + 3) / 4) * ((h + 3) / 4) * unit;
        else
          sum += w * h * unit;
        w = (w > 1) ? (w >> 1) : 64'd1;
        h = (h > 1) ? (h >> 1) : 64'd1;
      end
      total = sum * ((d.layers == '0) ? 64'd1 : 64'(d.layers))
                  * ((d.smp == '0) ? 64'd1 : 64'(d.smp));
      if (total > SIZE_SAT) begin
        total = SIZE_SAT;
        saturated++;
      end
      r.size_bytes = total[tmse_pkg::SIZE_W-1:0];
      r.format_known = 1'b1;
      return r;
    endfunction

    function void note_request(tex_desc_t d);
      pending_sizes.insert(pending_sizes.size(), estimate(d));
    endfunction

    function void check_result(logic [tmse_pkg::SIZE_W-1:0] size_bytes, logic format_known);
      size_estimate_t e;
      if (pending_sizes.size() == 0) begin
        $display("%0t: unexpected result size %0d known %0b", $time, size_bytes,
                 format_known);
        errors++;
        return;
      end
      e = pending_sizes.pop_front();
      checked++;
      if (size_bytes !== e.size_bytes) begin
        $display("%0t: size_bytes mismatch, expected %0d actual %0d", $time,
                 e.size_bytes, size_bytes);
        errors++;
      end
      if (format_known !== e.format_known) begin
        $display("%0t: format_known mismatch, expected %0b actual %0b", $time,
                 e.format_known, format_known);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_sizes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   sent;

  tmse_in_if  in_ch();
  tmse_out_if out_ch();

  size_scoreboard sb = new();

  texture_memory_size_estimator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // note every accepted texture description
  always @(posedge clk) begin
    tex_desc_t d;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      d.w = in_ch.tex_width;
      d.h = in_ch.tex_height;
      d.mips = in_ch.mip_count;
      d.layers = in_ch.layer_count;
      d.fmt = in_ch.pixel_format;
      d.smp = in_ch.samples;
      sb.note_request(d);
    end
  end

  // check every accepted estimate
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.size_bytes, out_ch.format_known);
  end

  // result side back-pressure in short bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // present one description and hold it until the transaction completes
  task automatic send_desc(tex_desc_t d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.tex_width    <= d.w;
    in_ch.tex_height   <= d.h;
    in_ch.mip_count    <= d.mips;
    in_ch.layer_count  <= d.layers;
    in_ch.pixel_format <= d.fmt;
    in_ch.samples      <= d.smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_fields(int w, int h, int mips, int layers, int fmt, int smp);
    tex_desc_t d;
    d.w = tmse_pkg::DIM_W'(w);
    d.h = tmse_pkg::DIM_W'(h);
    d.mips = tmse_pkg::LVL_W'(mips);
    d.layers = tmse_pkg::LAYER_W'(layers);
    d.fmt = tmse_pkg::FMT_W'(fmt);
    d.smp = tmse_pkg::SMP_W'(smp);
    send_desc(d);
  endtask

  // random description, mostly small and well formed, some past the stated ranges
  function automatic tex_desc_t random_desc();
    tex_desc_t d;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) d.fmt = tmse_pkg::FMT_W'($urandom_range(1, 99));
    else if (pick < 85) d.fmt = tmse_pkg::FMT_W'(($urandom_range(0, 1) == 0)
                                                 ? $urandom_range(70, 84)
                                                 : $urandom_range(94, 99));
    else d.fmt = tmse_pkg::FMT_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      d.w = tmse_pkg::DIM_W'($urandom_range(0, 64));
      d.h = tmse_pkg::DIM_W'($urandom_range(0, 64));
    end else if (pick < 85) begin
      d.w = tmse_pkg::DIM_W'($urandom_range(0, 16384));
      d.h = tmse_pkg::DIM_W'($urandom_range(0, 16384));
    end else begin
      d.w = tmse_pkg::DIM_W'($urandom_range(0, 32767));
      d.h = tmse_pkg::DIM_W'($urandom_range(0, 32767));
    end
    d.mips = tmse_pkg::LVL_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 50) d.layers = tmse_pkg::LAYER_W'($urandom_range(0, 4));
    else if (pick < 85) d.layers = tmse_pkg::LAYER_W'($urandom_range(0, 2048));
    else d.layers = tmse_pkg::LAYER_W'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    if (pick < 50) d.smp = tmse_pkg::SMP_W'(1 << $urandom_range(0, 3));
    else if (pick < 85) d.smp = tmse_pkg::SMP_W'($urandom_range(0, 32));
    else d.smp = tmse_pkg::SMP_W'($urandom_range(0, 63));
    return d;
  endfunction

  // reset, stimulus and end of run
  initial begin
    int guard;
    calm = 1'b0;
    sent = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.tex_width    <= '0;
    in_ch.tex_height   <= '0;
    in_ch.mip_count    <= '0;
    in_ch.layer_count  <= '0;
    in_ch.pixel_format <= '0;
    in_ch.samples      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero sizes, extremes, each format family except codes 90 to 93, unknown codes, saturation
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 0, 0, 2, 0);
    send_fields(16384, 16384, 0, 2048, 2, 32);
    send_fields(32767, 32767, 0, 4095, 2, 63);
    send_fields(16384, 1, 0, 1, 28, 1);
    send_fields(1, 16384, 15, 3, 61, 0);
    send_fields(5, 3, 15, 1, 71, 1);
    send_fields(4096, 4096, 0, 6, 98, 0);
    send_fields(100, 60, 3, 0, 6, 4);
    send_fields(640, 480, 0, 1, 10, 8);
    send_fields(17, 9, 2, 2, 50, 2);
    send_fields(32, 32, 0, 1, 66, 1);
    send_fields(32, 32, 0, 1, 68, 1);
    send_fields(32, 32, 0, 1, 85, 1);
    send_fields(32, 32, 0, 1, 89, 1);
    send_fields(32, 32, 0, 1, 100, 1);
    send_fields(32, 32, 0, 1, 255, 1);
    send_fields(256, 128, 1, 1, 67, 1);
    send_fields(63, 33, 4, 7, 83, 16);
    send_fields(2, 2, 0, 1, 94, 1);
    send_fields(1, 1, 0, 0, 87, 0);
    send_fields(7, 7, 0, 1, 76, 0);
    send_fields(12345, 300, 0, 1, 79, 1);

    // random part, back-pressure and gaps switched off towards the end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i >= CALM_FROM) calm = 1'b1;
      send_desc(random_desc());
    end
    in_ch.valid <= 1'b0;

    // drain outstanding estimates, then a short settle
    guard = 0;
    while (sb.outstanding() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d estimates never arrived", $time, sb.outstanding());
      sb.errors += sb.outstanding();
    end

    $display("covered %0d descriptions, %0d results checked", sent, sb.checked);
    $display("%0d unknown formats, %0d full chains, %0d saturated totals",
             sb.unknown_fmts, sb.full_chains, sb.saturated);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
